>>> sv/dfw_pkg.sv
package dfw_pkg;

    // field widths
    localparam int DEV_W   = 4;
    localparam int MASK_W  = 16;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 32;
    localparam int ENTRY_W = 5;
    localparam int ALLOW_ENTRIES = 4;
    localparam int ALLOW_W = ALLOW_ENTRIES * ENTRY_W;
    localparam int NUM_DEVICES = 16;

    // watcher states as seen on the output
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SEARCH = 2'd1,
        ST_ARMING = 2'd2
    } t_watch;

    // reason codes
    typedef enum logic [2:0] {
        RS_NONE        = 3'd0,
        RS_NOT_ARMED   = 3'd1,
        RS_DWELL       = 3'd2,
        RS_NO_REPL     = 3'd3,
        RS_WAIT_STABLE = 3'd4
    } t_reason;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_RULE_ARMED   = 2'd0,
        CFG_DWELL_MS     = 2'd1,
        CFG_STABILITY_MS = 2'd2,
        CFG_ALLOW_LIST   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic               rule_armed;
        logic [TIME_W-1:0]  dwell_ms;
        logic [TIME_W-1:0]  stability_ms;
        logic [ALLOW_W-1:0] allow_list;
    } t_cfg;

    typedef struct packed {
        logic [DEV_W-1:0]  cur_dev;
        logic              cur_valid;
        logic [DEV_W-1:0]  cand_dev;
        logic              cand_valid;
        t_watch            fsm;
        logic [TIME_W-1:0] armed_time;
        logic [TIME_W-1:0] commit_time;
        logic              has_committed;
        t_reason           reason;
    } t_state;

    typedef struct packed {
        logic              mode;
        logic [DEV_W-1:0]  device;
        logic [MASK_W-1:0] present_mask;
        logic [TIME_W-1:0] now_ms;
    } t_item;

endpackage

>>> sv/dfw_core.sv
module dfw_core (
    input  dfw_pkg::t_cfg   i_cfg,
    input  dfw_pkg::t_state i_state,
    input  dfw_pkg::t_item  i_item,
    output dfw_pkg::t_state o_state,
    output logic            o_pulse
);
    import dfw_pkg::*;

    // device counts as present only inside the device range
    function automatic logic dev_present(input logic [DEV_W-1:0] d,
                                         input logic [MASK_W-1:0] m);
        logic p;
        p = (int'(d) < NUM_DEVICES) && m[d];
        return p;
    endfunction

    logic [ENTRY_W-1:0] entry;
    logic               pick_ok;
    logic [DEV_W-1:0]   pick_dev;
    logic [TIME_W-1:0]  commit_age;
    logic [TIME_W-1:0]  armed_age;
    logic               cur_here;
    logic               dwell_hold;

    // priority pick over the allow list, entry 0 wins
    always_comb begin
        pick_ok  = 1'b0;
        pick_dev = '0;
        entry    = '0;
        for (int i = ALLOW_ENTRIES - 1; i >= 0; i--) begin
            entry = i_cfg.allow_list[i*ENTRY_W +: ENTRY_W];
            if (entry[ENTRY_W-1] && dev_present(entry[DEV_W-1:0], i_item.present_mask)) begin
                pick_ok  = 1'b1;
                pick_dev = entry[DEV_W-1:0];
            end
        end
    end

    // wrapping time differences
    assign commit_age = i_item.now_ms - i_state.commit_time;
    assign armed_age  = i_item.now_ms - i_state.armed_time;
    assign cur_here   = i_state.cur_valid && dev_present(i_state.cur_dev, i_item.present_mask);
    assign dwell_hold = i_state.has_committed && (i_cfg.dwell_ms != '0)
                        && (commit_age < i_cfg.dwell_ms);

    // next state for one word
    always_comb begin
        o_state = i_state;
        o_pulse = 1'b0;
        if (i_item.mode) begin
            if (!(i_state.cur_valid && i_state.cur_dev == i_item.device)) begin
                o_state.cur_dev    = i_item.device;
                o_state.cur_valid  = 1'b1;
                o_state.cand_dev   = '0;
                o_state.cand_valid = 1'b0;
                o_state.fsm        = ST_IDLE;
                o_state.armed_time = '0;
                o_state.reason     = RS_NONE;
            end
        end else if (!i_cfg.rule_armed) begin
            o_state.fsm        = ST_IDLE;
            o_state.cand_dev   = '0;
            o_state.cand_valid = 1'b0;
            o_state.reason     = RS_NOT_ARMED;
        end else if (cur_here) begin
            o_state.fsm        = ST_IDLE;
            o_state.cand_dev   = '0;
            o_state.cand_valid = 1'b0;
            o_state.armed_time = '0;
            o_state.reason     = RS_NONE;
        end else if (dwell_hold) begin
            o_state.fsm    = ST_SEARCH;
            o_state.reason = RS_DWELL;
        end else if (!pick_ok) begin
            o_state.fsm        = ST_SEARCH;
            o_state.cand_dev   = '0;
            o_state.cand_valid = 1'b0;
            o_state.armed_time = '0;
            o_state.reason     = RS_NO_REPL;
        end else if (i_state.fsm != ST_ARMING || !i_state.cand_valid
                     || i_state.cand_dev != pick_dev) begin
            o_state.fsm        = ST_ARMING;
            o_state.cand_valid = 1'b1;
            o_state.cand_dev   = pick_dev;
            o_state.armed_time = i_item.now_ms;
            o_state.reason     = RS_WAIT_STABLE;
        end else if (armed_age >= i_cfg.stability_ms) begin
            o_state.cur_dev       = i_state.cand_dev;
            o_state.cur_valid     = 1'b1;
            o_state.cand_dev      = '0;
            o_state.cand_valid    = 1'b0;
            o_state.fsm           = ST_IDLE;
            o_state.armed_time    = '0;
            o_state.commit_time   = i_item.now_ms;
            o_state.has_committed = 1'b1;
            o_state.reason        = RS_NONE;
            o_pulse               = 1'b1;
        end
    end

endmodule

>>> sv/device_failover_watcher.sv
// the result word is registered and shows in the cycle after its input word is accepted
// throughput: one word per cycle while each result word is taken, set by the single next-state pass in dfw_core
// the route state registers double as the result register; a new word is taken
// whenever the result register is empty or its word is taken in the same cycle
// reset (synchronous, active low) clears configuration, route state and valid
module device_failover_watcher (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [dfw_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_mode,
    input  logic [dfw_pkg::DEV_W-1:0]  i_device,
    input  logic [dfw_pkg::MASK_W-1:0] i_present_mask,
    input  logic [dfw_pkg::TIME_W-1:0] i_now_ms,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_watch_state,
    output logic                       o_candidate_valid,
    output logic [dfw_pkg::DEV_W-1:0]  o_candidate_device,
    output logic                       o_current_valid,
    output logic [dfw_pkg::DEV_W-1:0]  o_current_device,
    output logic                       o_commit_pulse,
    output logic [2:0]                 o_reason_code
);
    import dfw_pkg::*;

    t_cfg   r_cfg;
    t_state r_st;
    t_state n_st;
    t_item  item;
    logic   r_pulse;
    logic   n_pulse;
    logic   r_out_valid;
    logic   in_take;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_take    = i_in_valid && o_in_ready;

    assign item.mode         = i_mode;
    assign item.device       = i_device;
    assign item.present_mask = i_present_mask;
    assign item.now_ms       = i_now_ms;

    dfw_core u_core (
        .i_cfg   (r_cfg),
        .i_state (r_st),
        .i_item  (item),
        .o_state (n_st),
        .o_pulse (n_pulse)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RULE_ARMED:   r_cfg.rule_armed   <= i_cfg_data[0];
                CFG_DWELL_MS:     r_cfg.dwell_ms     <= i_cfg_data[TIME_W-1:0];
                CFG_STABILITY_MS: r_cfg.stability_ms <= i_cfg_data[TIME_W-1:0];
                CFG_ALLOW_LIST:   r_cfg.allow_list   <= i_cfg_data[ALLOW_W-1:0];
                default: ;
            endcase
        end
    end

    // route state and result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= '0;
            r_pulse     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_st    <= n_st;
                r_pulse <= n_pulse;
            end
            if (in_take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_watch_state      = r_st.fsm;
    assign o_candidate_valid  = r_st.cand_valid;
    assign o_candidate_device = r_st.cand_dev;
    assign o_current_valid    = r_st.cur_valid;
    assign o_current_device   = r_st.cur_dev;
    assign o_commit_pulse     = r_pulse;
    assign o_reason_code      = r_st.reason;

    // a commit leaves the route on a device with nothing armed
    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pulse |-> (r_st.cur_valid && r_st.fsm == ST_IDLE && !r_st.cand_valid))
        else $error("commit without idle route state");

    // arming always holds a candidate and waits for stability
    a_arming_cand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.fsm == ST_ARMING) |-> (r_st.cand_valid && r_st.reason == RS_WAIT_STABLE))
        else $error("arming without candidate");

    // route state moves only on an accepted word
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_take |=> $stable(r_st))
        else $error("route state changed without input word");

    // a pulse needs a prior commit record
    a_pulse_hist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pulse |-> r_st.has_committed)
        else $error("commit pulse without commit history");

endmodule
